[hw/rtl/fcp_pkg.sv]
// shared types, tag codes and helpers for the fcp tlv stream parser
// depends on nothing; used by the parser core, the result queue and the top
`default_nettype none

package fcp_pkg;

   // default number of value bytes kept in value_head
   localparam int HEAD_BYTES_DEFAULT = 8;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // result kinds
   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // container tags
   localparam logic [7:0] TAG_WRAPPER  = 8'h62;
   localparam logic [7:0] TAG_TEMPLATE = 8'hA5;

   // top-level element tags
   localparam logic [7:0] TAG_FILE_LEN = 8'h80;
   localparam logic [7:0] TAG_DESC     = 8'h82;
   localparam logic [7:0] TAG_FID      = 8'h83;
   localparam logic [7:0] TAG_NAME     = 8'h84;
   localparam logic [7:0] TAG_SFI      = 8'h88;
   localparam logic [7:0] TAG_LCS      = 8'h8A;
   localparam logic [7:0] TAG_SEC_ARF  = 8'h8B;

   // template element tags
   localparam logic [7:0] TAG_INNER    = 8'h81;
   localparam logic [7:0] TAG_KEY_85   = 8'h85;
   localparam logic [7:0] TAG_KEY_86   = 8'h86;
   localparam logic [7:0] TAG_KEY_87   = 8'h87;
   localparam logic [7:0] TAG_KEY_89   = 8'h89;
   localparam logic [7:0] TAG_KEY_8E   = 8'h8E;

   // file type byte codes
   localparam logic [7:0] FT_KEY_A = 8'h11;
   localparam logic [7:0] FT_KEY_B = 8'h51;
   localparam logic [7:0] FT_DIR_A = 8'h38;
   localparam logic [7:0] FT_DIR_B = 8'h78;
   localparam logic [7:0] FT_BIN_A = 8'h01;
   localparam logic [7:0] FT_BIN_B = 8'h41;

   // parser phase, one-hot
   typedef enum logic [2:0] {
      PH_TAG = 3'b001,
      PH_LEN = 3'b010,
      PH_VAL = 3'b100
   } fcp_phase_type;

   // one result item
   typedef struct packed {
      logic        kind;
      logic [7:0]  tag_code;
      logic        in_template;
      logic [7:0]  value_length;
      logic [63:0] value_head;
      logic [15:0] file_id;
      logic [15:0] file_bytes;
      logic        is_dir_file;
      logic        is_binary_file;
      logic        is_key_file;
      logic        truncated;
      logic        run_last;
   } fcp_result_type;

   // everything one input byte produces
   typedef struct packed {
      logic [1:0]     count;
      fcp_result_type first;
      fcp_result_type second;
   } fcp_step_type;

   // is this tag reported as an element
   function automatic logic tag_known(input logic [7:0] tag, input logic inner,
                                      input logic keyset);
      logic hit;
      hit = 1'b0;
      if (!inner) begin
         hit = (tag == TAG_FILE_LEN) || (tag == TAG_DESC) || (tag == TAG_FID) ||
               (tag == TAG_NAME) || (tag == TAG_SFI) || (tag == TAG_LCS) ||
               (tag == TAG_SEC_ARF);
      end else if (keyset) begin
         hit = (tag == TAG_KEY_85) || (tag == TAG_KEY_86) || (tag == TAG_KEY_87) ||
               (tag == TAG_KEY_89) || (tag == TAG_SEC_ARF) || (tag == TAG_KEY_8E);
      end else begin
         hit = (tag == TAG_INNER);
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/fcp_ifs.sv]
// valid/ready channel interfaces for the fcp parser: byte input and result output
// depends on fcp_pkg for nothing but sits after it in compile order
`default_nettype none

interface fcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       frame_end;

   modport source (output valid, output byte_in, output frame_end, input ready);
   modport sink (input valid, input byte_in, input frame_end, output ready);
endinterface

interface fcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tag_code;
   logic        in_template;
   logic [7:0]  value_length;
   logic [63:0] value_head;
   logic [15:0] file_id;
   logic [15:0] file_bytes;
   logic        is_dir_file;
   logic        is_binary_file;
   logic        is_key_file;
   logic        truncated;
   logic        run_last;

   modport source (output valid, output kind, output tag_code, output in_template,
                   output value_length, output value_head, output file_id,
                   output file_bytes, output is_dir_file, output is_binary_file,
                   output is_key_file, output truncated, output run_last,
                   input ready);
   modport sink (input valid, input kind, input tag_code, input in_template,
                 input value_length, input value_head, input file_id,
                 input file_bytes, input is_dir_file, input is_binary_file,
                 input is_key_file, input truncated, input run_last,
                 output ready);
endinterface

`default_nettype wire

[hw/rtl/fcp_tlv_stream_parser.sv]
// top level of the fcp tlv stream parser: byte channel in, result channel out
// depends on fcp_pkg, fcp_ifs, fcp_core and fcp_out_fifo
`default_nettype none

// Parses an FCP response one byte per cycle into tag/length/value elements.
// Every accepted byte updates the parser state in the same cycle and drops its
// results (none, one element, a summary, or an element then a summary on the
// final byte) into a four-entry result queue. A byte is taken whenever the queue
// has room for two results, so bytes flow one per cycle while the result side
// keeps up; results leave one per cycle while the result side is ready, and
// the only stall source is a queue without room for two results. Results
// are registered in the queue. The byte marked frame_end ends the frame and
// the parser returns to its reset state for the next one.
module fcp_tlv_stream_parser #(
   parameter int HEAD_BYTES = fcp_pkg::HEAD_BYTES_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   fcp_req_if.sink    req_chan,
   fcp_rsp_if.source  rsp_chan
);

   fcp_pkg::fcp_step_type   step_res;
   fcp_pkg::fcp_result_type head_res;
   logic                    room;
   logic                    accept;
   logic                    out_valid;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   // parser
   fcp_core #(
      .HEAD_BYTES (HEAD_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .byte_in   (req_chan.byte_in),
      .frame_end (req_chan.frame_end),
      .result    (step_res)
   );

   // result queue
   fcp_out_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .wr_data  (step_res),
      .room     (room),
      .rd_valid (out_valid),
      .rd_ready (rsp_chan.ready),
      .rd_data  (head_res)
   );

   // result channel
   assign rsp_chan.valid          = out_valid;
   assign rsp_chan.kind           = head_res.kind;
   assign rsp_chan.tag_code       = head_res.tag_code;
   assign rsp_chan.in_template    = head_res.in_template;
   assign rsp_chan.value_length   = head_res.value_length;
   assign rsp_chan.value_head     = head_res.value_head;
   assign rsp_chan.file_id        = head_res.file_id;
   assign rsp_chan.file_bytes     = head_res.file_bytes;
   assign rsp_chan.is_dir_file    = head_res.is_dir_file;
   assign rsp_chan.is_binary_file = head_res.is_binary_file;
   assign rsp_chan.is_key_file    = head_res.is_key_file;
   assign rsp_chan.truncated      = head_res.truncated;
   assign rsp_chan.run_last       = head_res.run_last;

   // a frame-ending byte always leaves a result queued
   a_frame_end_result: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.frame_end) |=> rsp_chan.valid)
      else $error("no result queued after frame end");

   // input stalls only while results are pending
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with empty result queue");

   // a summary is always the last result of its byte
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == fcp_pkg::KIND_SUMMARY) |-> rsp_chan.run_last)
      else $error("summary not marked as last result");

endmodule

`default_nettype wire

[hw/rtl/fcp_core.sv]
// tlv parser state and single-byte step logic; produces up to two results per byte
// depends on fcp_pkg
`default_nettype none

module fcp_core #(
   parameter int HEAD_BYTES = fcp_pkg::HEAD_BYTES_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  wire  [7:0]           byte_in,
   input  wire                  frame_end,
   output fcp_pkg::fcp_step_type result
);

   // parser state
   fcp_pkg::fcp_phase_type phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  left_ff, left_in;
   logic        inside_ff, inside_in;
   logic [7:0]  tleft_ff, tleft_in;
   logic        tkey_ff, tkey_in;
   logic [63:0] head_ff, head_in;
   logic        keyseen_ff, keyseen_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] size_ff, size_in;
   logic [7:0]  type_ff, type_in;
   logic        tpres_ff, tpres_in;
   logic        overrun_ff, overrun_in;

   logic        done;
   logic        elem_hit;
   logic [7:0]  pos;
   logic [7:0]  left_dec;
   fcp_pkg::fcp_result_type elem_res;
   fcp_pkg::fcp_result_type sum_res;

   assign pos      = len_ff - left_ff;
   assign left_dec = left_ff - 8'd1;

   // next state for one byte
   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      inside_in  = inside_ff;
      tleft_in   = inside_ff ? (tleft_ff - 8'd1) : tleft_ff;
      tkey_in    = tkey_ff;
      head_in    = head_ff;
      keyseen_in = keyseen_ff;
      id_in      = id_ff;
      size_in    = size_ff;
      type_in    = type_ff;
      tpres_in   = tpres_ff;
      overrun_in = overrun_ff;
      done       = 1'b0;

      unique case (phase_ff)
         fcp_pkg::PH_LEN: begin
            len_in   = byte_in;
            left_in  = byte_in;
            head_in  = '0;
            phase_in = fcp_pkg::PH_TAG;
            if (!inside_ff && tag_ff == fcp_pkg::TAG_WRAPPER) begin
               // wrapper body is parsed in place
            end else if (!inside_ff && tag_ff == fcp_pkg::TAG_TEMPLATE) begin
               if (byte_in != 8'd0) begin
                  inside_in = 1'b1;
                  tleft_in  = byte_in;
                  tkey_in   = keyseen_ff;
               end
            end else begin
               if (!inside_ff) begin
                  if (tag_ff == fcp_pkg::TAG_FILE_LEN) size_in = '0;
                  if (tag_ff == fcp_pkg::TAG_FID) id_in = '0;
                  if (tag_ff == fcp_pkg::TAG_DESC) begin
                     type_in    = '0;
                     tpres_in   = (byte_in != 8'd0);
                     keyseen_in = 1'b0;
                  end
               end
               if (byte_in == 8'd0) done = 1'b1;
               else phase_in = fcp_pkg::PH_VAL;
            end
         end
         fcp_pkg::PH_VAL: begin
            if (pos < 8'(HEAD_BYTES)) head_in = {head_ff[55:0], byte_in};
            if (!inside_ff) begin
               if (tag_ff == fcp_pkg::TAG_FILE_LEN) begin
                  if (pos == 8'd0) size_in = {byte_in, 8'h00};
                  else if (pos == 8'd1) size_in = size_ff | {8'h00, byte_in};
               end else if (tag_ff == fcp_pkg::TAG_FID) begin
                  if (pos == 8'd0) id_in = {byte_in, 8'h00};
                  else if (pos == 8'd1) id_in = id_ff | {8'h00, byte_in};
               end else if (tag_ff == fcp_pkg::TAG_DESC && pos == 8'd0) begin
                  type_in    = byte_in;
                  keyseen_in = (byte_in == fcp_pkg::FT_KEY_A) ||
                               (byte_in == fcp_pkg::FT_KEY_B);
               end
            end
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = fcp_pkg::PH_TAG;
               done     = 1'b1;
            end
         end
         fcp_pkg::PH_TAG: begin
            tag_in   = byte_in;
            phase_in = fcp_pkg::PH_LEN;
         end
         default: begin
            phase_in = fcp_pkg::PH_TAG;
         end
      endcase

      // element reported before the template end check
      elem_hit = done && fcp_pkg::tag_known(tag_ff, inside_ff, tkey_in);

      // template closes: drop an unfinished inner element
      if (inside_ff && tleft_in == 8'd0) begin
         if (phase_in != fcp_pkg::PH_TAG) begin
            overrun_in = 1'b1;
            phase_in   = fcp_pkg::PH_TAG;
         end
         inside_in = 1'b0;
      end
   end

   // element result
   always_comb begin
      elem_res              = '0;
      elem_res.kind         = fcp_pkg::KIND_ELEMENT;
      elem_res.tag_code     = tag_ff;
      elem_res.in_template  = inside_ff;
      elem_res.value_length = len_in;
      elem_res.value_head   = head_in;
      elem_res.run_last     = !frame_end;
   end

   // end-of-frame summary
   always_comb begin
      sum_res                = '0;
      sum_res.kind           = fcp_pkg::KIND_SUMMARY;
      sum_res.file_id        = id_in;
      sum_res.file_bytes     = size_in;
      sum_res.is_dir_file    = tpres_in && ((type_in == fcp_pkg::FT_DIR_A) ||
                                            (type_in == fcp_pkg::FT_DIR_B));
      sum_res.is_binary_file = tpres_in && ((type_in == fcp_pkg::FT_BIN_A) ||
                                            (type_in == fcp_pkg::FT_BIN_B));
      sum_res.is_key_file    = tpres_in && ((type_in == fcp_pkg::FT_KEY_A) ||
                                            (type_in == fcp_pkg::FT_KEY_B));
      sum_res.truncated      = overrun_in || (phase_in != fcp_pkg::PH_TAG) || inside_in;
      sum_res.run_last       = 1'b1;
   end

   // pack results in order
   always_comb begin
      result.count  = {1'b0, elem_hit} + {1'b0, frame_end};
      result.first  = elem_hit ? elem_res : sum_res;
      result.second = sum_res;
   end

   // state registers; frame end returns to reset state
   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         phase_ff   <= fcp_pkg::PH_TAG;
         tag_ff     <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         inside_ff  <= 1'b0;
         tleft_ff   <= '0;
         tkey_ff    <= 1'b0;
         head_ff    <= '0;
         keyseen_ff <= 1'b0;
         id_ff      <= '0;
         size_ff    <= '0;
         type_ff    <= '0;
         tpres_ff   <= 1'b0;
         overrun_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         tag_ff     <= tag_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         inside_ff  <= inside_in;
         tleft_ff   <= tleft_in;
         tkey_ff    <= tkey_in;
         head_ff    <= head_in;
         keyseen_ff <= keyseen_in;
         id_ff      <= id_in;
         size_ff    <= size_in;
         type_ff    <= type_in;
         tpres_ff   <= tpres_in;
         overrun_ff <= overrun_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/fcp_out_fifo.sv]
// result queue: takes up to two result items a cycle, hands out one while the reader is ready
// depends on fcp_pkg
`default_nettype none

module fcp_out_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  fcp_pkg::fcp_step_type   wr_data,
   output logic                    room,
   output logic                    rd_valid,
   input  wire                     rd_ready,
   output fcp_pkg::fcp_result_type rd_data
);

   localparam int PW = fcp_pkg::FIFO_PTR_W;
   localparam int CW = fcp_pkg::FIFO_CNT_W;

   fcp_pkg::fcp_result_type mem_ff [fcp_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_push;
   logic          pop;
   logic [PW-1:0] wr_ptr_nx;

   // status
   assign room      = (cnt_ff <= CW'(fcp_pkg::FIFO_DEPTH - 2));
   assign rd_valid  = (cnt_ff != '0);
   assign pop       = rd_valid && rd_ready;
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign n_push    = push ? CW'(wr_data.count) : '0;
   assign wr_ptr_nx = wr_ptr_ff + PW'(1);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(n_push);
      rd_ptr_in = pop ? (rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      cnt_in    = cnt_ff + n_push - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (n_push != '0) mem_ff[wr_ptr_ff] <= wr_data.first;
      if (n_push == CW'(2)) mem_ff[wr_ptr_nx] <= wr_data.second;
   end

endmodule

`default_nettype wire
